// ===== hdl/ctk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ctk_pkg;

  typedef enum logic [3:0] {
    KIND_END       = 4'd0,
    KIND_SYMBOL    = 4'd1,
    KIND_SEPARATOR = 4'd2,
    KIND_COMMENT   = 4'd3,
    KIND_PREPROC   = 4'd4,
    KIND_STRING    = 4'd5,
    KIND_CHARLIT   = 4'd6,
    KIND_NUMBER    = 4'd7,
    KIND_KEYWORD   = 4'd8
  } kind_t;

  localparam logic [3:0] KW_NONE   = 4'd0;
  localparam logic [3:0] KW_CHAR   = 4'd1;
  localparam logic [3:0] KW_INT    = 4'd2;
  localparam logic [3:0] KW_FLOAT  = 4'd3;
  localparam logic [3:0] KW_VOID   = 4'd4;
  localparam logic [3:0] KW_BOOL   = 4'd5;
  localparam logic [3:0] KW_CONST  = 4'd6;
  localparam logic [3:0] KW_STATIC = 4'd7;
  localparam logic [3:0] KW_INLINE = 4'd8;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_NL  = 8'h0A;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  kw;
    logic [31:0] offset;
    logic [15:0] length;
    logic [19:0] row;
    logic [15:0] column;
    logic        last;
  } tok_t;

  // results of one processed byte, tok[0] first
  typedef struct packed {
    logic [1:0]      n;
    tok_t [1:0]      tok;
  } emit_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == ".") || (c == ",") || (c == ";") || (c == "(") || (c == ")") ||
           (c == "[") || (c == "]") || (c == "{") || (c == "}") || (c == "*") ||
           (c == "=");
  endfunction

  // w[0] is the first byte of the symbol
  function automatic logic [3:0] kw_lookup(input logic [5:0][7:0] w,
                                           input logic [15:0]     len);
    logic [3:0] id;
    id = KW_NONE;
    if (len == 16'd4 && {w[0], w[1], w[2], w[3]} == "char") id = KW_CHAR;
    if (len == 16'd3 && {w[0], w[1], w[2]} == "int") id = KW_INT;
    if (len == 16'd5 && {w[0], w[1], w[2], w[3], w[4]} == "float") id = KW_FLOAT;
    if (len == 16'd4 && {w[0], w[1], w[2], w[3]} == "void") id = KW_VOID;
    if (len == 16'd4 && {w[0], w[1], w[2], w[3]} == "bool") id = KW_BOOL;
    if (len == 16'd5 && {w[0], w[1], w[2], w[3], w[4]} == "const") id = KW_CONST;
    if (len == 16'd6 && {w[0], w[1], w[2], w[3], w[4], w[5]} == "static") id = KW_STATIC;
    if (len == 16'd6 && {w[0], w[1], w[2], w[3], w[4], w[5]} == "inline") id = KW_INLINE;
    return id;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ctk_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ctk_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface ctk_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [3:0]  keyword_id;
  logic [31:0] token_offset;
  logic [15:0] token_length;
  logic [19:0] token_row;
  logic [15:0] token_column;
  logic        last;

  modport source (output valid, output token_kind, output keyword_id, output token_offset,
                  output token_length, output token_row, output token_column,
                  output last, input ready);
  modport sink   (input valid, input token_kind, input keyword_id, input token_offset,
                  input token_length, input token_row, input token_column,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/ctk_lexer.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctk_lexer #(
  parameter logic [31:0] MAX_TOKEN_LENGTH     = 32'd65535,
  parameter int          KEYWORD_BUFFER_BYTES = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           go,
  input  logic [7:0]     char_code,
  output ctk_pkg::emit_t emit
);

  localparam logic [15:0] LEN_CAP =
    (MAX_TOKEN_LENGTH > 32'd65535) ? 16'hFFFF : MAX_TOKEN_LENGTH[15:0];
  localparam int KBW = $clog2(KEYWORD_BUFFER_BYTES);
  localparam logic [15:0] KB_LEN = 16'(KEYWORD_BUFFER_BYTES);

  typedef enum logic [3:0] {
    M_IDLE, M_PRE, M_PRE_ESC, M_CM_SLASH, M_CM_LINE, M_CM_LINE_ESC,
    M_CM_BLOCK, M_CM_BLOCK_ESC, M_CM_BLOCK_STAR, M_CM_TRAIL, M_STR,
    M_STR_ESC, M_CHAR, M_NUM_INT, M_NUM_FRAC, M_SYM
  } mode_t;

  mode_t          mode_r, mode_nxt;
  ctk_pkg::kind_t pkind_r, pkind_nxt;
  logic [31:0]    poff_r, poff_nxt;
  logic [15:0]    plen_r, plen_nxt;
  logic [19:0]    prow_r, prow_nxt;
  logic [15:0]    pcol_r, pcol_nxt;
  logic [31:0]    boff_r, boff_nxt;
  logic [19:0]    crow_r, crow_nxt;
  logic [15:0]    ccol_r, ccol_nxt;
  logic [7:0]     wbuf_r [KEYWORD_BUFFER_BYTES];
  logic [7:0]     wbuf_nxt [KEYWORD_BUFFER_BYTES];
  logic           wlong_r, wlong_nxt;
  logic [1:0]     ccnt_r, ccnt_nxt;

  logic             emit_old, do_idle, add_cur, close_cur, close_new, eot;
  logic [5:0][7:0]  w6;
  logic [3:0]       old_kw;
  ctk_pkg::tok_t    old_tok, pend_tok, end_tok;
  ctk_pkg::emit_t   emit_c;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      w6[i] = wbuf_r[i];
    end
  end

  assign old_kw = (pkind_r == ctk_pkg::KIND_SYMBOL && !wlong_r) ?
                  ctk_pkg::kw_lookup(w6, plen_r) : ctk_pkg::KW_NONE;

  always_comb begin
    old_tok.kind   = (old_kw != ctk_pkg::KW_NONE) ? ctk_pkg::KIND_KEYWORD : pkind_r;
    old_tok.kw     = old_kw;
    old_tok.offset = poff_r;
    old_tok.length = plen_r;
    old_tok.row    = prow_r;
    old_tok.column = pcol_r;
    old_tok.last   = 1'b0;
  end

  always_comb begin
    mode_nxt  = mode_r;
    pkind_nxt = pkind_r;
    poff_nxt  = poff_r;
    plen_nxt  = plen_r;
    prow_nxt  = prow_r;
    pcol_nxt  = pcol_r;
    wbuf_nxt  = wbuf_r;
    wlong_nxt = wlong_r;
    ccnt_nxt  = ccnt_r;
    emit_old  = 1'b0;
    do_idle   = 1'b0;
    add_cur   = 1'b0;
    close_cur = 1'b0;
    close_new = 1'b0;
    eot       = (char_code == ctk_pkg::CH_NUL);

    case (mode_r)
      M_IDLE: begin
        do_idle = 1'b1;
      end
      M_PRE: begin
        if (char_code == ctk_pkg::CH_NL) begin
          emit_old = 1'b1;
          do_idle  = 1'b1;
        end else begin
          add_cur = 1'b1;
          if (char_code == "\\") mode_nxt = M_PRE_ESC;
        end
      end
      M_PRE_ESC: begin
        add_cur  = 1'b1;
        mode_nxt = M_PRE;
      end
      M_CM_SLASH: begin
        if (char_code == "/") begin
          add_cur  = 1'b1;
          mode_nxt = M_CM_LINE;
        end else if (char_code == "*") begin
          add_cur  = 1'b1;
          mode_nxt = M_CM_BLOCK_STAR;
        end else if (ctk_pkg::is_space(char_code)) begin
          add_cur  = 1'b1;
          mode_nxt = M_CM_TRAIL;
        end else begin
          emit_old = 1'b1;
          do_idle  = 1'b1;
        end
      end
      M_CM_LINE: begin
        add_cur = 1'b1;
        if (char_code == ctk_pkg::CH_NL) mode_nxt = M_CM_TRAIL;
        else if (char_code == "\\") mode_nxt = M_CM_LINE_ESC;
      end
      M_CM_LINE_ESC: begin
        add_cur  = 1'b1;
        mode_nxt = M_CM_LINE;
      end
      M_CM_BLOCK: begin
        add_cur = 1'b1;
        if (char_code == "\\") mode_nxt = M_CM_BLOCK_ESC;
        else if (char_code == "*") mode_nxt = M_CM_BLOCK_STAR;
      end
      M_CM_BLOCK_ESC: begin
        add_cur  = 1'b1;
        mode_nxt = M_CM_BLOCK;
      end
      M_CM_BLOCK_STAR: begin
        add_cur  = 1'b1;
        mode_nxt = (char_code == "/") ? M_CM_TRAIL : M_CM_BLOCK;
      end
      M_CM_TRAIL: begin
        if (ctk_pkg::is_space(char_code)) begin
          add_cur = 1'b1;
        end else if (char_code == "/") begin
          add_cur  = 1'b1;
          mode_nxt = M_CM_SLASH;
        end else begin
          emit_old = 1'b1;
          do_idle  = 1'b1;
        end
      end
      M_STR: begin
        add_cur = 1'b1;
        if (char_code == "\"") close_cur = 1'b1;
        else if (char_code == "\\") mode_nxt = M_STR_ESC;
      end
      M_STR_ESC: begin
        add_cur  = 1'b1;
        mode_nxt = M_STR;
      end
      M_CHAR: begin
        add_cur = 1'b1;
        if (ccnt_r == 2'd3) ccnt_nxt = (char_code == "\\") ? 2'd2 : 2'd1;
        else if (ccnt_r == 2'd2) ccnt_nxt = 2'd1;
        else begin
          ccnt_nxt  = 2'd0;
          close_cur = 1'b1;
        end
      end
      M_NUM_INT: begin
        if (ctk_pkg::is_digit(char_code)) begin
          add_cur = 1'b1;
        end else if (char_code == ".") begin
          add_cur  = 1'b1;
          mode_nxt = M_NUM_FRAC;
        end else begin
          emit_old = 1'b1;
          do_idle  = 1'b1;
        end
      end
      M_NUM_FRAC: begin
        if (ctk_pkg::is_digit(char_code)) begin
          add_cur = 1'b1;
        end else begin
          emit_old = 1'b1;
          do_idle  = 1'b1;
        end
      end
      M_SYM: begin
        if (ctk_pkg::is_sep(char_code) || ctk_pkg::is_space(char_code)) begin
          emit_old = 1'b1;
          do_idle  = 1'b1;
        end else begin
          add_cur = 1'b1;
        end
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    if (close_cur || emit_old || do_idle) mode_nxt = M_IDLE;

    if (add_cur) begin
      if (mode_r == M_SYM && !wlong_r) begin
        if (plen_r < KB_LEN) wbuf_nxt[plen_r[KBW-1:0]] = char_code;
        else wlong_nxt = 1'b1;
      end
      if (plen_r < LEN_CAP) plen_nxt = plen_r + 16'd1;
    end

    if (do_idle && !ctk_pkg::is_space(char_code)) begin
      poff_nxt  = boff_r;
      prow_nxt  = crow_r;
      pcol_nxt  = ccol_r;
      plen_nxt  = 16'd1;
      wlong_nxt = 1'b0;
      if (char_code == "#") begin
        pkind_nxt = ctk_pkg::KIND_PREPROC;
        mode_nxt  = M_PRE;
      end else if (ctk_pkg::is_sep(char_code)) begin
        pkind_nxt = ctk_pkg::KIND_SEPARATOR;
        close_new = 1'b1;
      end else if (char_code == "/") begin
        pkind_nxt = ctk_pkg::KIND_COMMENT;
        mode_nxt  = M_CM_SLASH;
      end else if (char_code == "\"") begin
        pkind_nxt = ctk_pkg::KIND_STRING;
        mode_nxt  = M_STR;
      end else if (char_code == "'") begin
        pkind_nxt = ctk_pkg::KIND_CHARLIT;
        mode_nxt  = M_CHAR;
        ccnt_nxt  = 2'd3;
      end else if (ctk_pkg::is_digit(char_code)) begin
        pkind_nxt = ctk_pkg::KIND_NUMBER;
        mode_nxt  = M_NUM_INT;
      end else begin
        pkind_nxt   = ctk_pkg::KIND_SYMBOL;
        mode_nxt    = M_SYM;
        wbuf_nxt[0] = char_code;
      end
    end

    boff_nxt = (boff_r != 32'hFFFF_FFFF) ? boff_r + 32'd1 : boff_r;
    if (char_code == ctk_pkg::CH_NL) begin
      crow_nxt = (crow_r != 20'hF_FFFF) ? crow_r + 20'd1 : crow_r;
      ccol_nxt = 16'd1;
    end else begin
      crow_nxt = crow_r;
      ccol_nxt = (ccol_r != 16'hFFFF) ? ccol_r + 16'd1 : ccol_r;
    end

    // end of text: back to reset state
    if (eot) begin
      mode_nxt  = M_IDLE;
      pkind_nxt = ctk_pkg::KIND_END;
      poff_nxt  = 32'd0;
      plen_nxt  = 16'd0;
      prow_nxt  = 20'd1;
      pcol_nxt  = 16'd1;
      boff_nxt  = 32'd0;
      crow_nxt  = 20'd1;
      ccol_nxt  = 16'd1;
      wlong_nxt = 1'b0;
      ccnt_nxt  = 2'd0;
    end
  end

  always_comb begin
    pend_tok.kind   = pkind_nxt;
    pend_tok.kw     = ctk_pkg::KW_NONE;
    pend_tok.offset = poff_nxt;
    pend_tok.length = plen_nxt;
    pend_tok.row    = prow_nxt;
    pend_tok.column = pcol_nxt;
    pend_tok.last   = 1'b1;

    end_tok.kind   = ctk_pkg::KIND_END;
    end_tok.kw     = ctk_pkg::KW_NONE;
    end_tok.offset = boff_r;
    end_tok.length = 16'd0;
    end_tok.row    = crow_r;
    end_tok.column = ccol_r;
    end_tok.last   = 1'b1;

    if (eot) begin
      emit_c.n      = (mode_r != M_IDLE) ? 2'd2 : 2'd1;
      emit_c.tok[1] = end_tok;
      emit_c.tok[0] = (mode_r != M_IDLE) ? old_tok : end_tok;
    end else begin
      emit_c.n      = {1'b0, emit_old} + {1'b0, close_cur || close_new};
      emit_c.tok[1] = pend_tok;
      emit_c.tok[0] = emit_old ? old_tok : pend_tok;
    end
    emit_c.tok[0].last = (emit_c.n == 2'd1);
    if (!go) emit_c.n = 2'd0;
  end

  assign emit = emit_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pkind_r <= ctk_pkg::KIND_END;
      poff_r  <= 32'd0;
      plen_r  <= 16'd0;
      prow_r  <= 20'd1;
      pcol_r  <= 16'd1;
      boff_r  <= 32'd0;
      crow_r  <= 20'd1;
      ccol_r  <= 16'd1;
      wlong_r <= 1'b0;
      ccnt_r  <= 2'd0;
    end else if (go) begin
      mode_r  <= mode_nxt;
      pkind_r <= pkind_nxt;
      poff_r  <= poff_nxt;
      plen_r  <= plen_nxt;
      prow_r  <= prow_nxt;
      pcol_r  <= pcol_nxt;
      boff_r  <= boff_nxt;
      crow_r  <= crow_nxt;
      ccol_r  <= ccol_nxt;
      wlong_r <= wlong_nxt;
      ccnt_r  <= ccnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go) wbuf_r <= wbuf_nxt;
  end

`ifndef SYNTHESIS
  a_two_results_kind: assert property (@(posedge clk) disable iff (!rst_n)
    emit.n == 2'd2 |-> (emit.tok[1].kind == ctk_pkg::KIND_SEPARATOR ||
                        emit.tok[1].kind == ctk_pkg::KIND_END))
    else $error("second result of a byte is neither separator nor end");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    emit.n == 2'd2 |-> (!emit.tok[0].last && emit.tok[1].last))
    else $error("last flag misplaced on two-result byte");

  a_eot_restart: assert property (@(posedge clk) disable iff (!rst_n)
    go && char_code == ctk_pkg::CH_NUL |=>
      (mode_r == M_IDLE && boff_r == 32'd0 && crow_r == 20'd1 && ccol_r == 16'd1))
    else $error("position not restarted after end of text");
`endif

endmodule

`default_nettype wire

// ===== hdl/c_source_tokenizer_top.sv =====
// C source tokenizer.
// in_chan (valid/ready) carries one source byte per transfer; byte 0 ends the
// text, flushes any open token, emits an end token and restarts positions.
// out_chan (valid/ready) carries one token per transfer: kind, keyword id,
// offset, length, row, column, and last on the final token caused by a byte.
// A byte yields zero, one or two tokens.
// A token caused by a byte is offered once that byte has passed the input
// register and then the lexer step that writes the result queue.
// Throughput: one byte per cycle while each byte yields at most one token and
// out_chan accepts each token; the single result port limits it to one token
// per cycle, so bytes giving two tokens lower the byte rate.
// A four-entry result queue sits between the lexer and out_chan; the lexer
// steps only when at least two entries are free, so a stalled receiver backs
// up the queue and then in_chan.ready drops. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the queue and the input register and
// returns the lexer to row 1, column 1, offset 0, between tokens.
`timescale 1ns / 1ps
`default_nettype none

module c_source_tokenizer_top #(
  parameter logic [31:0] MAX_TOKEN_LENGTH     = 32'd65535,
  parameter int          KEYWORD_BUFFER_BYTES = 6
) (
  input  logic      clk,
  input  logic      rst_n,
  ctk_in_if.sink    in_chan,
  ctk_out_if.source out_chan
);

  localparam int QDEPTH = 4;

  logic [7:0]     byte_r;
  logic           bvld_r;
  logic           go;
  ctk_pkg::emit_t emit;

  ctk_pkg::tok_t  q_r [QDEPTH];
  logic [1:0]     rd_r, wr_r;
  logic [2:0]     cnt_r;
  logic           pop;
  ctk_pkg::tok_t  head;

  assign go            = bvld_r && (cnt_r <= 3'd2);
  assign in_chan.ready = !bvld_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvld_r <= 1'b0;
    end else if (in_chan.valid && in_chan.ready) begin
      bvld_r <= 1'b1;
    end else if (go) begin
      bvld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) byte_r <= in_chan.char_code;
  end

  ctk_lexer #(
    .MAX_TOKEN_LENGTH    (MAX_TOKEN_LENGTH),
    .KEYWORD_BUFFER_BYTES(KEYWORD_BUFFER_BYTES)
  ) u_lexer (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (go),
    .char_code(byte_r),
    .emit     (emit)
  );

  assign pop = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 2'd0;
      wr_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      rd_r  <= rd_r + {1'b0, pop};
      wr_r  <= wr_r + emit.n;
      cnt_r <= cnt_r + {1'b0, emit.n} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (emit.n != 2'd0) q_r[wr_r] <= emit.tok[0];
    if (emit.n == 2'd2) q_r[wr_r + 2'd1] <= emit.tok[1];
  end

  assign head = q_r[rd_r];

  assign out_chan.valid        = (cnt_r != 3'd0);
  assign out_chan.token_kind   = head.kind;
  assign out_chan.keyword_id   = head.kw;
  assign out_chan.token_offset = head.offset;
  assign out_chan.token_length = head.length;
  assign out_chan.token_row    = head.row;
  assign out_chan.token_column = head.column;
  assign out_chan.last         = head.last;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QDEPTH))
    else $error("result queue overflow");

  a_held_byte: assert property (@(posedge clk) disable iff (!rst_n)
    bvld_r && !go |=> (bvld_r && $stable(byte_r)))
    else $error("waiting byte lost or changed");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 3'd0 && emit.n == 2'd0 |=> cnt_r == 3'd0)
    else $error("queue count moved without a transfer");
`endif

endmodule

`default_nettype wire

// ===== tb/c_source_tokenizer_top_tb.sv =====
`timescale 1ns / 1ps

typedef enum int {
  LM_IDLE, LM_PRE, LM_PRE_ESC, LM_CM_SLASH, LM_CM_LINE, LM_CM_LINE_ESC,
  LM_CM_BLOCK, LM_CM_BLOCK_ESC, LM_CM_STAR, LM_CM_TRAIL, LM_STR, LM_STR_ESC,
  LM_CHAR, LM_NUM_INT, LM_NUM_FRAC, LM_SYM
} lex_mode_t;

class token_scoreboard;
  ctk_pkg::tok_t  expected_q[$];
  ctk_pkg::tok_t  step_q[$];
  int             errors;
  lex_mode_t      mode;
  ctk_pkg::kind_t pend_kind;
  logic [31:0]    pend_off;
  logic [15:0]    pend_len;
  logic [19:0]    pend_row;
  logic [15:0]    pend_col;
  logic [31:0]    byte_off;
  logic [19:0]    cur_row;
  logic [15:0]    cur_col;
  logic [7:0]     word [6];
  logic           too_long;
  logic [1:0]     char_left;

  function new();
    errors = 0;
    clear();
  endfunction

  function void clear();
    mode = LM_IDLE;
    pend_kind = ctk_pkg::KIND_END;
    pend_off = '0;
    pend_len = '0;
    pend_row = 20'd1;
    pend_col = 16'd1;
    byte_off = '0;
    cur_row = 20'd1;
    cur_col = 16'd1;
    foreach (word[i]) word[i] = 8'd0;
    too_long = 1'b0;
    char_left = 2'd0;
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction

  function bit blank_byte(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function bit digit_byte(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function bit sep_byte(logic [7:0] c);
    return c == "." || c == "," || c == ";" || c == "(" || c == ")" || c == "[" ||
           c == "]" || c == "{" || c == "}" || c == "*" || c == "=";
  endfunction

  function logic [3:0] keyword_of();
    logic [47:0] w;
    w = {word[0], word[1], word[2], word[3], word[4], word[5]};
    case (pend_len)
      16'd3: begin
        if (w[47:24] == "int") return ctk_pkg::KW_INT;
      end
      16'd4: begin
        if (w[47:16] == "char") return ctk_pkg::KW_CHAR;
        if (w[47:16] == "void") return ctk_pkg::KW_VOID;
        if (w[47:16] == "bool") return ctk_pkg::KW_BOOL;
      end
      16'd5: begin
        if (w[47:8] == "float") return ctk_pkg::KW_FLOAT;
        if (w[47:8] == "const") return ctk_pkg::KW_CONST;
      end
      16'd6: begin
        if (w == "static") return ctk_pkg::KW_STATIC;
        if (w == "inline") return ctk_pkg::KW_INLINE;
      end
      default: ;
    endcase
    return ctk_pkg::KW_NONE;
  endfunction

  function void emit_pending();
    ctk_pkg::tok_t t;
    t.kind = pend_kind;
    t.kw = ctk_pkg::KW_NONE;
    if (pend_kind == ctk_pkg::KIND_SYMBOL && !too_long) begin
      t.kw = keyword_of();
      if (t.kw != ctk_pkg::KW_NONE) t.kind = ctk_pkg::KIND_KEYWORD;
    end
    t.offset = pend_off;
    t.length = pend_len;
    t.row = pend_row;
    t.column = pend_col;
    t.last = 1'b0;
    step_q.push_back(t);
    mode = LM_IDLE;
  endfunction

  function void add_byte(logic [7:0] c);
    if (mode == LM_SYM && !too_long) begin
      if (pend_len < 16'd6) word[pend_len] = c;
      else too_long = 1'b1;
    end
    if (pend_len != 16'hFFFF) pend_len++;
  endfunction

  function void open_token(ctk_pkg::kind_t k, lex_mode_t m, logic [7:0] c);
    pend_kind = k;
    pend_off = byte_off;
    pend_row = cur_row;
    pend_col = cur_col;
    pend_len = '0;
    too_long = 1'b0;
    mode = m;
    add_byte(c);
  endfunction

  function void from_idle(logic [7:0] c);
    if (blank_byte(c)) return;
    if (c == "#") open_token(ctk_pkg::KIND_PREPROC, LM_PRE, c);
    else if (sep_byte(c)) begin
      open_token(ctk_pkg::KIND_SEPARATOR, LM_IDLE, c);
      emit_pending();
    end else if (c == "/") open_token(ctk_pkg::KIND_COMMENT, LM_CM_SLASH, c);
    else if (c == "\"") open_token(ctk_pkg::KIND_STRING, LM_STR, c);
    else if (c == "'") begin
      open_token(ctk_pkg::KIND_CHARLIT, LM_CHAR, c);
      char_left = 2'd3;
    end else if (digit_byte(c)) open_token(ctk_pkg::KIND_NUMBER, LM_NUM_INT, c);
    else open_token(ctk_pkg::KIND_SYMBOL, LM_SYM, c);
  endfunction

  // one accepted byte: works out the tokens it releases
  function void note_byte(logic [7:0] c);
    bit            again;
    ctk_pkg::tok_t t;
    step_q.delete();
    if (c == ctk_pkg::CH_NUL) begin
      if (mode != LM_IDLE) emit_pending();
      t.kind = ctk_pkg::KIND_END;
      t.kw = ctk_pkg::KW_NONE;
      t.offset = byte_off;
      t.length = '0;
      t.row = cur_row;
      t.column = cur_col;
      t.last = 1'b1;
      step_q.push_back(t);
      foreach (step_q[i]) expected_q.push_back(step_q[i]);
      clear();
      return;
    end
    do begin
      again = 1'b0;
      case (mode)
        LM_IDLE: from_idle(c);
        LM_PRE: begin
          if (c == ctk_pkg::CH_NL) begin
            emit_pending();
            again = 1'b1;
          end else begin
            add_byte(c);
            if (c == "\\") mode = LM_PRE_ESC;
          end
        end
        LM_PRE_ESC: begin
          add_byte(c);
          mode = LM_PRE;
        end
        LM_CM_SLASH: begin
          if (c == "/") begin
            add_byte(c);
            mode = LM_CM_LINE;
          end else if (c == "*") begin
            add_byte(c);
            mode = LM_CM_STAR;
          end else begin
            mode = LM_CM_TRAIL;
            again = 1'b1;
          end
        end
        LM_CM_LINE: begin
          if (c == ctk_pkg::CH_NL) begin
            mode = LM_CM_TRAIL;
            again = 1'b1;
          end else begin
            add_byte(c);
            if (c == "\\") mode = LM_CM_LINE_ESC;
          end
        end
        LM_CM_LINE_ESC: begin
          add_byte(c);
          mode = LM_CM_LINE;
        end
        LM_CM_BLOCK: begin
          add_byte(c);
          if (c == "\\") mode = LM_CM_BLOCK_ESC;
          else if (c == "*") mode = LM_CM_STAR;
        end
        LM_CM_BLOCK_ESC: begin
          add_byte(c);
          mode = LM_CM_BLOCK;
        end
        LM_CM_STAR: begin
          add_byte(c);
          mode = (c == "/") ? LM_CM_TRAIL : LM_CM_BLOCK;
        end
        LM_CM_TRAIL: begin
          if (blank_byte(c)) add_byte(c);
          else if (c == "/") begin
            add_byte(c);
            mode = LM_CM_SLASH;
          end else begin
            emit_pending();
            again = 1'b1;
          end
        end
        LM_STR: begin
          add_byte(c);
          if (c == "\"") emit_pending();
          else if (c == "\\") mode = LM_STR_ESC;
        end
        LM_STR_ESC: begin
          add_byte(c);
          mode = LM_STR;
        end
        LM_CHAR: begin
          add_byte(c);
          if (char_left == 2'd3) char_left = (c == "\\") ? 2'd2 : 2'd1;
          else if (char_left == 2'd2) char_left = 2'd1;
          else begin
            char_left = 2'd0;
            emit_pending();
          end
        end
        LM_NUM_INT: begin
          if (digit_byte(c)) add_byte(c);
          else if (c == ".") begin
            add_byte(c);
            mode = LM_NUM_FRAC;
          end else begin
            emit_pending();
            again = 1'b1;
          end
        end
        LM_NUM_FRAC: begin
          if (digit_byte(c)) add_byte(c);
          else begin
            emit_pending();
            again = 1'b1;
          end
        end
        LM_SYM: begin
          if (sep_byte(c) || blank_byte(c)) begin
            emit_pending();
            again = 1'b1;
          end else add_byte(c);
        end
        default: begin
          mode = LM_IDLE;
          again = 1'b1;
        end
      endcase
    end while (again);

    if (byte_off != 32'hFFFF_FFFF) byte_off++;
    if (c == ctk_pkg::CH_NL) begin
      if (cur_row != 20'hF_FFFF) cur_row++;
      cur_col = 16'd1;
    end else if (cur_col != 16'hFFFF) begin
      cur_col++;
    end
    if (step_q.size() != 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) expected_q.push_back(step_q[i]);
  endfunction

  function void field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: token %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endfunction

  function void check_token(ctk_pkg::tok_t got);
    ctk_pkg::tok_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected token, expected none, actual kind %0d offset %0d",
               $time, got.kind, got.offset);
      return;
    end
    want = expected_q.pop_front();
    field("kind", want.kind, got.kind);
    field("keyword_id", want.kw, got.kw);
    field("offset", want.offset, got.offset);
    field("length", want.length, got.length);
    field("row", want.row, got.row);
    field("column", want.column, got.column);
    field("last", want.last, got.last);
  endfunction
endclass

module c_source_tokenizer_top_tb;

  logic clk;
  logic rst_n;
  bit   idle_on = 1'b1;
  bit   hold_req = 1'b0;

  logic [7:0] text_q[$];
  token_scoreboard sb;

  ctk_in_if  in_if ();
  ctk_out_if out_if ();

  c_source_tokenizer_top u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] any_letter();
    case ($urandom_range(3))
      0: return 8'("A" + $urandom_range(25));
      1: return "_";
      default: return 8'("a" + $urandom_range(25));
    endcase
  endfunction

  function automatic logic [7:0] any_blank();
    int r;
    r = $urandom_range(5);
    return (r == 5) ? 8'd32 : 8'(9 + r);
  endfunction

  function automatic logic [7:0] any_sep();
    string s;
    s = ".,;()[]{}*=";
    return s[$urandom_range(10)];
  endfunction

  function automatic logic [7:0] token_end();
    return $urandom_range(1) ? any_sep() : any_blank();
  endfunction

  // one well-formed or slightly broken piece of source
  function automatic void add_fragment();
    int    pick;
    int    n;
    int    r;
    string w;
    string odd;
    string kw_words [8];
    kw_words = '{"char", "int", "float", "void", "bool", "const", "static", "inline"};
    odd = "+-<>!&|%^~?:@$#/\"'\\";
    pick = $urandom_range(99);
    if (pick < 18) begin
      w = kw_words[$urandom_range(7)];
      r = $urandom_range(7);
      if (r == 0) put_text(w.substr(0, w.len() - 2));
      else put_text(w);
      if (r == 1) text_q.push_back(any_letter());
      text_q.push_back(token_end());
    end else if (pick < 30) begin
      text_q.push_back(any_letter());
      n = $urandom_range(8);
      repeat (n) begin
        r = $urandom_range(99);
        if (r < 10) text_q.push_back(8'($urandom_range(128, 255)));
        else if (r < 20) text_q.push_back(8'("0" + $urandom_range(9)));
        else if (r < 28) text_q.push_back(odd[$urandom_range(odd.len() - 1)]);
        else text_q.push_back(any_letter());
      end
      text_q.push_back(token_end());
    end else if (pick < 40) begin
      repeat ($urandom_range(1, 4)) text_q.push_back(8'("0" + $urandom_range(9)));
      if ($urandom_range(1)) begin
        text_q.push_back(".");
        repeat ($urandom_range(3)) text_q.push_back(8'("0" + $urandom_range(9)));
      end
      text_q.push_back($urandom_range(2) == 0 ? any_letter() : token_end());
    end else if (pick < 48) begin
      text_q.push_back("\"");
      repeat ($urandom_range(6)) begin
        r = $urandom_range(9);
        if (r == 0) put_text("\\\"");
        else if (r == 1) begin
          text_q.push_back("\\");
          text_q.push_back(any_letter());
        end else if (r == 2) text_q.push_back(any_blank());
        else text_q.push_back(any_letter());
      end
      if ($urandom_range(9) != 0) text_q.push_back("\"");
    end else if (pick < 54) begin
      text_q.push_back("'");
      if ($urandom_range(1)) text_q.push_back("\\");
      text_q.push_back($urandom_range(4) == 0 ? 8'("'") : any_letter());
      text_q.push_back("'");
    end else if (pick < 60) begin
      put_text("//");
      repeat ($urandom_range(6)) begin
        r = $urandom_range(9);
        if (r == 0) put_text("\\\n");
        else if (r == 1) text_q.push_back(" ");
        else text_q.push_back(any_letter());
      end
      text_q.push_back(ctk_pkg::CH_NL);
      if ($urandom_range(2) == 0) begin
        text_q.push_back(any_blank());
        put_text("//x\n");
      end
    end else if (pick < 67) begin
      r = $urandom_range(9);
      if (r == 0) put_text("/*/");
      else if (r == 1) put_text("/**/*/");
      else begin
        put_text("/*");
        repeat ($urandom_range(6)) begin
          r = $urandom_range(9);
          if (r == 0) put_text("*");
          else if (r == 1) put_text("\\");
          else if (r == 2) text_q.push_back(any_blank());
          text_q.push_back(any_letter());
        end
        put_text("*/");
      end
    end else if (pick < 73) begin
      text_q.push_back("#");
      repeat ($urandom_range(6)) begin
        r = $urandom_range(9);
        if (r == 0) put_text("\\\n");
        else if (r == 1) text_q.push_back(" ");
        else text_q.push_back(any_letter());
      end
      text_q.push_back(ctk_pkg::CH_NL);
    end else if (pick < 82) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(any_sep());
    end else if (pick < 89) begin
      repeat ($urandom_range(1, 3)) text_q.push_back(any_blank());
    end else if (pick < 92) begin
      text_q.push_back("/");
      text_q.push_back($urandom_range(1) ? any_blank() : any_letter());
    end else if (pick < 97) begin
      text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      text_q.push_back(ctk_pkg::CH_NUL);
    end
  endfunction

  function automatic void fill_random(int count);
    int goal;
    goal = text_q.size() + count;
    while (text_q.size() < goal) add_fragment();
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_bytes();
    logic [7:0] b;
    while (text_q.size() != 0) begin
      b = text_q.pop_front();
      if (idle_on) begin
        while ($urandom_range(99) < 31) begin
          in_if.valid <= 1'b0;
          @(negedge clk);
        end
      end
      in_if.valid <= 1'b1;
      in_if.char_code <= b;
      do @(posedge clk); while (in_if.ready !== 1'b1);
      sb.note_byte(b);
      @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : result_sink
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(99) < 31);
      end
    end
  end

  always @(posedge clk) begin
    ctk_pkg::tok_t got;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.kind = ctk_pkg::kind_t'(out_if.token_kind);
      got.kw = out_if.keyword_id;
      got.offset = out_if.token_offset;
      got.length = out_if.token_length;
      got.row = out_if.token_row;
      got.column = out_if.token_column;
      got.last = out_if.last;
      sb.check_token(got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < 2000) begin
      @(posedge clk);
      if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
          (out_if.valid === 1'b1 && out_if.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("[c_source_tokenizer_top] ERROR");
    $finish;
  end

  initial begin : main_flow
    sb = new();
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.char_code = 8'd0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // escaped newline in a directive, keyword, lone-slash comment run,
    // escaped char literal and string, number ended by a dot, high byte
    put_text("#d\\\n\nint /*/ / '\\''\"\\\"\"7.2.");
    text_q.push_back(8'hFF);
    text_q.push_back(ctk_pkg::CH_NUL);
    send_bytes();
    wait_drained();

    fill_random(250);
    send_bytes();

    // result side stalls while separators keep arriving
    hold_req = 1'b1;
    repeat (40) text_q.push_back(any_sep());
    fill_random(60);
    send_bytes();

    idle_on = 1'b0;
    fill_random(200);
    send_bytes();
    idle_on = 1'b1;

    fill_random(220);
    text_q.push_back(ctk_pkg::CH_NUL);
    send_bytes();
    wait_drained();

    if (sb.errors == 0) begin
      $display("[c_source_tokenizer_top] OK");
    end else begin
      $display("[c_source_tokenizer_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== c_source_tokenizer_top.f =====
hdl/ctk_pkg.sv
hdl/ctk_if.sv
hdl/ctk_lexer.sv
hdl/c_source_tokenizer_top.sv
tb/c_source_tokenizer_top_tb.sv
